>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the similarity block.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define CHECK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition on one edge implies another on the next edge.
`define CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/psim_pkg.sv
// Package for the Pearson similarity block: payload types, command and status
// structs, controller states and datapath widths. No dependencies.
package psim_pkg;

	localparam int unsigned RatingW = 8;
	localparam int unsigned AvgW    = 16;
	localparam int unsigned UserW   = 16;
	localparam int unsigned SimW    = 16;
	localparam int unsigned SumW    = 64;
	localparam int unsigned DevW    = 17;
	localparam int unsigned ProdW   = 34;
	localparam int unsigned MulW    = 32;
	localparam int unsigned SqW     = 128;
	localparam int unsigned WideW   = 162;
	localparam int unsigned LShift  = 30;
	localparam logic [RatingW-1:0] NotRated = 8'd255;

	typedef struct packed {
		logic [RatingW-1:0] rating_target;
		logic [RatingW-1:0] rating_other;
		logic [AvgW-1:0]    avg_other;
		logic [UserW-1:0]   other_user;
		logic               last_movie;
	} in_req_t;

	typedef struct packed {
		logic [UserW-1:0] user_out;
		logic [SimW-1:0]  similarity;
		logic             is_similar;
	} out_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_ACC,
		ST_CHK,
		ST_MUL,
		ST_MADD,
		ST_CALC,
		ST_CMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load_dev;
		logic       prod;
		logic       acc;
		logic       init;
		logic       mul;
		logic       madd;
		logic [2:0] part;
		logic       calc;
		logic       cmp;
		logic [3:0] bit_idx;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic similar;
	} status_t;

endpackage

>>> rtl/pearson_user_similarity.sv
// Pearson similarity between a target user and one other user.
// The next item is taken while one that is not last accumulates; accumulation is one product stage.
// A last item that is similar passes the 32x32 partial products and then the Q1.15 bit
// search before its result is loaded; otherwise its result is loaded from the check state.
// Reset clears the sums, the average register and all control state; it needs no sweep.
`include "assert_macros.svh"
module pearson_user_similarity (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [psim_pkg::AvgW-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  psim_pkg::in_req_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output psim_pkg::out_req_t        out_data
);

	psim_pkg::cmd_t    cmd;
	psim_pkg::status_t status;

	psim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	psim_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

	// A waiting result is never overwritten, and loading it clears the sums.
	`CHECK_IMPL(a_no_overwrite, out_valid && !out_ready, !cmd.load_out, "result overwritten")
	`CHECK_NEXT(a_load_valid, cmd.load_out, out_valid, "loaded result not presented")
	`CHECK_NEXT(a_sums_clear, cmd.load_out, !status.similar, "sums not cleared")

endmodule

>>> rtl/psim_ctrl.sv
// Controller state machine for the Pearson similarity block.
// Depends on psim_pkg; drives the datapath through psim_pkg::cmd_t.
module psim_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  psim_pkg::status_t status,
	output psim_pkg::cmd_t    cmd
);

	psim_pkg::state_t state_q, state_d;
	logic [2:0] part_q, part_d;
	logic [3:0] bit_q, bit_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psim_pkg::ST_IDLE;
			part_q      <= 3'd0;
			bit_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			part_q  <= part_d;
			bit_q   <= bit_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		part_d   = part_q;
		bit_d    = bit_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.part    = part_q;
		cmd.bit_idx = bit_q;
		case (state_q)
			psim_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_dev = 1'b1;
					state_d = psim_pkg::ST_PROD;
				end
			end
			psim_pkg::ST_PROD: begin
				cmd.prod = 1'b1;
				state_d = psim_pkg::ST_ACC;
			end
			psim_pkg::ST_ACC: begin
				cmd.acc  = 1'b1;
				in_ready = !status.last;
				if (in_valid && !status.last) begin
					cmd.load_dev = 1'b1;
					state_d = psim_pkg::ST_PROD;
				end else if (status.last) begin
					state_d = psim_pkg::ST_CHK;
				end else begin
					state_d = psim_pkg::ST_IDLE;
				end
			end
			psim_pkg::ST_CHK: begin
				if (status.similar) begin
					cmd.init = 1'b1;
					part_d = 3'd0;
					state_d = psim_pkg::ST_MUL;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = psim_pkg::ST_IDLE;
				end
			end
			psim_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = psim_pkg::ST_MADD;
			end
			psim_pkg::ST_MADD: begin
				cmd.madd = 1'b1;
				part_d = part_q + 3'd1;
				if (part_q == 3'd7) begin
					bit_d = 4'd15;
					state_d = psim_pkg::ST_CALC;
				end else begin
					state_d = psim_pkg::ST_MUL;
				end
			end
			psim_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				state_d = psim_pkg::ST_CMP;
			end
			psim_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				bit_d = bit_q - 4'd1;
				if (bit_q == 4'd0) begin
					state_d = psim_pkg::ST_OUT;
				end else begin
					state_d = psim_pkg::ST_CALC;
				end
			end
			psim_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = psim_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = psim_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/psim_dp.sv
// Datapath for the Pearson similarity block: deviations, sums, wide products,
// the bit-by-bit ratio search and the result register. Depends on psim_pkg.
module psim_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [psim_pkg::AvgW-1:0]     cfg_wdata,
	input  psim_pkg::in_req_t             in_data,
	input  psim_pkg::cmd_t                cmd,
	output psim_pkg::status_t             status,
	output psim_pkg::out_req_t            out_data
);

	localparam int unsigned W = psim_pkg::WideW;

	logic [psim_pkg::AvgW-1:0]         avg_target_q;
	logic signed [psim_pkg::DevW-1:0]  dt_s1, do_s1;
	logic                              skip_s1, last_s1;
	logic [psim_pkg::UserW-1:0]        user_s1;
	logic signed [psim_pkg::ProdW-1:0] pc_s2, pt_s2, po_s2;
	logic                              skip_s2;
	logic [psim_pkg::SumW-1:0]         sum_c_q, sum_t_q, sum_o_q;
	logic [psim_pkg::SqW-1:0]          l_q;
	logic [W-1:0]                      p_q, r2p_q, rp_q, t_q;
	logic [psim_pkg::SimW-1:0]         r_q;
	logic [2*psim_pkg::MulW-1:0]       mul_q;
	logic [psim_pkg::MulW-1:0]         mul_a, mul_b;
	logic [psim_pkg::SumW-1:0]         src_a, src_b;
	logic [psim_pkg::SqW-1:0]          mul_ext;
	logic [W-1:0]                      l_cmp;
	logic [4:0]                        sh_rp, sh_p;
	psim_pkg::out_req_t                out_q;

	assign src_a   = cmd.part[2] ? sum_t_q : sum_c_q;
	assign src_b   = cmd.part[2] ? sum_o_q : sum_c_q;
	assign mul_a   = cmd.part[1] ? src_a[63:32] : src_a[31:0];
	assign mul_b   = cmd.part[0] ? src_b[63:32] : src_b[31:0];
	assign mul_ext = {64'd0, mul_q} << (7'(cmd.part[1]) * 7'd32 + 7'(cmd.part[0]) * 7'd32);
	assign l_cmp   = {4'd0, l_q, 30'd0};
	assign sh_rp   = {1'b0, cmd.bit_idx} + 5'd1;
	assign sh_p    = {cmd.bit_idx, 1'b0};

	assign status.last    = last_s1;
	assign status.similar = (sum_c_q != '0) && !sum_c_q[63] && (sum_t_q != '0)
		&& (sum_o_q != '0);
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_target_q <= '0;
			sum_c_q      <= '0;
			sum_t_q      <= '0;
			sum_o_q      <= '0;
			last_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				avg_target_q <= cfg_wdata;
			end
			if (cmd.load_dev) begin
				last_s1 <= in_data.last_movie;
			end
			if (cmd.acc && !skip_s2) begin
				sum_c_q <= sum_c_q + 64'(pc_s2);
				sum_t_q <= sum_t_q + 64'(pt_s2);
				sum_o_q <= sum_o_q + 64'(po_s2);
			end
			if (cmd.load_out) begin
				sum_c_q <= '0;
				sum_t_q <= '0;
				sum_o_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_dev) begin
			dt_s1   <= $signed({1'b0, in_data.rating_target, 8'd0})
				- $signed({1'b0, avg_target_q});
			do_s1   <= $signed({1'b0, in_data.rating_other, 8'd0})
				- $signed({1'b0, in_data.avg_other});
			skip_s1 <= (in_data.rating_target == psim_pkg::NotRated)
				|| (in_data.rating_other == psim_pkg::NotRated);
			user_s1 <= in_data.other_user;
		end
		if (cmd.prod) begin
			pc_s2   <= dt_s1 * do_s1;
			pt_s2   <= dt_s1 * dt_s1;
			po_s2   <= do_s1 * do_s1;
			skip_s2 <= skip_s1;
		end
		if (cmd.init) begin
			l_q   <= '0;
			p_q   <= '0;
			r2p_q <= '0;
			rp_q  <= '0;
			r_q   <= '0;
		end
		if (cmd.mul) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.madd) begin
			if (cmd.part[2]) begin
				p_q <= p_q + W'(mul_ext);
			end else begin
				l_q <= l_q + mul_ext;
			end
		end
		if (cmd.calc) begin
			t_q <= r2p_q + (rp_q << sh_rp) + (p_q << sh_p);
		end
		if (cmd.cmp && !r_q[15] && (t_q <= l_cmp)) begin
			r2p_q <= t_q;
			rp_q  <= rp_q + (p_q << cmd.bit_idx);
			r_q   <= r_q | (16'd1 << cmd.bit_idx);
		end
		if (cmd.load_out) begin
			out_q.user_out   <= user_s1;
			out_q.similarity <= status.similar ? r_q : '0;
			out_q.is_similar <= status.similar;
		end
	end

endmodule

>>> dv/tb_pearson_user_similarity.sv
// Testbench for pearson_user_similarity: random and directed rating requests
// with a bit-exact similarity predictor and a result scoreboard.
// Depends on psim_pkg and the pearson_user_similarity RTL.
`timescale 1ns / 1ps
module tb_pearson_user_similarity;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [psim_pkg::AvgW-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	psim_pkg::in_req_t in_data;
	logic out_valid;
	logic out_ready;
	psim_pkg::out_req_t out_data;

	pearson_user_similarity dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	psim_pkg::in_req_t pending_reqs[$];
	psim_pkg::out_req_t expected_sims[$];
	logic [15:0] avg_target_q;
	logic [63:0] acc_cross, acc_tsq, acc_osq;
	int send_idle_pct, recv_idle_pct;
	int errors;
	int cycle_count;
	logic hold_off;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic queue_req(psim_pkg::in_req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// Largest r in 0..32768 with r*r*t*o <= c*c*2^30.
	function automatic logic [15:0] q15_similarity(logic [63:0] c, logic [63:0] t,
			logic [63:0] o);
		logic [161:0] lhs, rhs;
		logic [16:0] r, cand;
		r = '0;
		lhs = ({98'd0, c} * {98'd0, c}) << 30;
		for (int b = 15; b >= 0; b--) begin
			cand = r | (17'd1 << b);
			if (cand <= 17'd32768) begin
				rhs = {98'd0, t} * {98'd0, o} * {145'd0, cand} * {145'd0, cand};
				if (rhs <= lhs)
					r = cand;
			end
		end
		return r[15:0];
	endfunction

	task automatic predict_similarity(psim_pkg::in_req_t req);
		logic signed [63:0] dt, dv;
		psim_pkg::out_req_t res;
		if (req.rating_target != psim_pkg::NotRated && req.rating_other != psim_pkg::NotRated) begin
			dt = $signed({48'd0, req.rating_target, 8'd0}) - $signed({48'd0, avg_target_q});
			dv = $signed({48'd0, req.rating_other, 8'd0}) - $signed({48'd0, req.avg_other});
			acc_cross += dt * dv;
			acc_tsq += dt * dt;
			acc_osq += dv * dv;
		end
		if (req.last_movie) begin
			res.user_out = req.other_user;
			res.is_similar = (acc_cross != 0 && !acc_cross[63] && acc_tsq != 0 && acc_osq != 0);
			res.similarity = res.is_similar ? q15_similarity(acc_cross, acc_tsq, acc_osq) : 16'd0;
			expected_sims.insert(expected_sims.size(), res);
			acc_cross = '0;
			acc_tsq = '0;
			acc_osq = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_similarity(in_data);
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && !hold_off &&
						$urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_reqs.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sims.size() == 0) begin
					$display("%0t: unexpected request, actual %h", $time, out_data);
					errors++;
				end else begin
					if (out_data !== expected_sims[0]) begin
						$display({"%0t: mismatch expected user %h sim %h flag %b,",
							" actual user %h sim %h flag %b"},
							$time, expected_sims[0].user_out, expected_sims[0].similarity,
							expected_sims[0].is_similar, out_data.user_out,
							out_data.similarity, out_data.is_similar);
						errors++;
					end
					void'(expected_sims.pop_front());
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 1500000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic psim_pkg::in_req_t rand_req(logic [15:0] ao, logic [15:0] user, bit last);
		psim_pkg::in_req_t r;
		r.rating_target = ($urandom_range(9) == 0) ? psim_pkg::NotRated : 8'($urandom);
		r.rating_other = ($urandom_range(9) == 0) ? psim_pkg::NotRated : 8'($urandom);
		r.avg_other = ao;
		r.other_user = user;
		r.last_movie = last;
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_sims.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_avg(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		avg_target_q <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_runs(int n_items);
		int left, len;
		logic [15:0] ao, user;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
			ao = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(256, 1500));
			user = 16'($urandom);
			for (int i = 0; i < len; i++) begin
				psim_pkg::in_req_t r;
				r = rand_req(ao, user, i == len - 1);
				if ($urandom_range(4) == 0)
					r.rating_target = 8'($urandom_range(1, 5));
				queue_req(r);
			end
			left -= len;
		end
	endtask

	initial begin
		errors = 0;
		cycle_count = 0;
		hold_off = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		avg_target_q = '0;
		acc_cross = '0;
		acc_tsq = '0;
		acc_osq = '0;
		send_idle_pct = 35;
		recv_idle_pct = 46;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: reset average, extremes, skipped pairs, identical users.
		queue_req('{8'd0, 8'd0, 16'd0, 16'd0, 1'b1});
		queue_req('{8'd255, 8'd3, 16'd0, 16'hFFFF, 1'b1});
		queue_req('{8'd4, 8'd255, 16'd0, 16'd1, 1'b1});
		queue_req('{8'd1, 8'd1, 16'd0, 16'd2, 1'b0});
		queue_req('{8'd254, 8'd254, 16'd0, 16'd2, 1'b1});
		wait_drained();
		write_avg(16'h0300);
		queue_req('{8'd1, 8'd1, 16'h0300, 16'd5, 1'b0});
		queue_req('{8'd5, 8'd5, 16'h0300, 16'd5, 1'b1});
		queue_req('{8'd1, 8'd5, 16'h0300, 16'd6, 1'b0});
		queue_req('{8'd5, 8'd1, 16'h0300, 16'd6, 1'b1});
		queue_req('{8'd3, 8'd3, 16'h0300, 16'd7, 1'b1});
		queue_req('{8'd1, 8'd2, 16'h0100, 16'd8, 1'b0});
		queue_req('{8'd5, 8'd4, 16'hFFFF, 16'd8, 1'b1});
		queue_req('{8'd255, 8'd255, 16'h0300, 16'd9, 1'b1});
		wait_drained();
		write_avg(16'hFFFF);
		queue_req('{8'd0, 8'd0, 16'hFFFF, 16'hAAAA, 1'b0});
		queue_req('{8'd254, 8'd254, 16'hFFFF, 16'h5555, 1'b1});
		queue_runs(300);
		wait_drained();
		write_avg(16'h0280);
		send_idle_pct = 46;
		recv_idle_pct = 35;
		queue_runs(300);
		wait_drained();
		write_avg(16'($urandom));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_runs(170);
		repeat (150) @(posedge clk);
		hold_off = 1'b1;
		while (in_valid || expected_sims.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_off = 1'b0;
		queue_runs(170);
		wait_drained();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
